[rtl/multitouch_centroid_tracker_unit_macros.svh]
// ---------------------------------------------------------------------------
// multitouch centroid tracker assertion macros
// shared concurrent assertion forms used by the tracker modules
// ---------------------------------------------------------------------------
`ifndef MULTITOUCH_CENTROID_TRACKER_UNIT_MACROS_SVH
`define MULTITOUCH_CENTROID_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MCTS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MCTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mcts_pkg.sv]
// ---------------------------------------------------------------------------
// mcts_pkg
// sizes, codes and table port structs of the multitouch centroid tracker
// ---------------------------------------------------------------------------
package mcts_pkg;

    // contact table size and derived widths
    localparam int MAX_CONTACTS = 16;
    localparam int IDX_W        = $clog2(MAX_CONTACTS);
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
    localparam int ID_W         = 32;
    localparam int COORD_W      = 16;
    localparam int SUM_W        = COORD_W + IDX_W;
    localparam int OUT_CNT_W    = 5;
    localparam int DIV_STEP_W   = $clog2(SUM_W);

    // event opcodes
    typedef enum logic [1:0] {
        OP_DOWN  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_UP    = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    // gesture sample kinds
    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    // table write controls
    typedef struct packed {
        logic                       wr_pos;
        logic                       set_new;
        logic                       clr_one;
        logic                       clr_all;
        logic [IDX_W-1:0]           idx;
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_tbl_wr;

    // table read data
    typedef struct packed {
        logic                       valid;
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_tbl_rd;

endpackage

[rtl/multitouch_centroid_tracker_unit.sv]
// ---------------------------------------------------------------------------
// multitouch_centroid_tracker_unit
// touch contact table that turns down/move/up/clear events into gesture samples
// ---------------------------------------------------------------------------
// Usage:
//   An event transaction is taken at a rising edge with start high and busy
//   low (i_opcode, i_contact_id, i_x_pos, i_y_pos). busy stays high until
//   the event is finished. Every event yields exactly one result transaction,
//   shown for one cycle with o_valid high: o_emit, o_event_kind,
//   o_pointer_count, o_center_x, o_center_y, o_overflow.
//   Sequence: the sequencer walks the 16-entry slot table once to find the
//   contact, a free slot and the live count, decides, and for an event that
//   produces a sample walks the table again to sum the coordinates and runs
//   the serial divider, one quotient bit per cycle over the 20-bit sums.
//   The table walks and the divider iterations set how long busy stays
//   high for an event.
//   Reset (synchronous, active low) empties the table, clears the gesture
//   flag and returns the sequencer to idle; o_valid is low after reset.
//   The receiver cannot stall: o_valid is a one-cycle strobe.
// ---------------------------------------------------------------------------
`include "multitouch_centroid_tracker_unit_macros.svh"

module multitouch_centroid_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic [mcts_pkg::ID_W-1:0]           i_contact_id,
    input  logic signed [mcts_pkg::COORD_W-1:0] i_x_pos,
    input  logic signed [mcts_pkg::COORD_W-1:0] i_y_pos,
    output logic                                o_valid,
    output logic                                o_emit,
    output logic [1:0]                          o_event_kind,
    output logic [mcts_pkg::OUT_CNT_W-1:0]      o_pointer_count,
    output logic signed [mcts_pkg::COORD_W-1:0] o_center_x,
    output logic signed [mcts_pkg::COORD_W-1:0] o_center_y,
    output logic                                o_overflow
);
    import mcts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUM,
        S_DIV
    } t_state;

    // sequencer and event registers
    t_state                     r_state,      n_state;
    t_opcode                    r_op,         n_op;
    logic [ID_W-1:0]            r_id,         n_id;
    logic signed [COORD_W-1:0]  r_x,          n_x;
    logic signed [COORD_W-1:0]  r_y,          n_y;
    logic [IDX_W-1:0]           r_idx,        n_idx;
    logic                       r_found,      n_found;
    logic [IDX_W-1:0]           r_match,      n_match;
    logic                       r_free_found, n_free_found;
    logic [IDX_W-1:0]           r_free,       n_free;
    logic [CNT_W-1:0]           r_count,      n_count;
    logic [CNT_W-1:0]           r_n,          n_n;
    t_kind                      r_kind,       n_kind;
    logic                       r_active,     n_active;
    logic                       r_remove,     n_remove;
    logic signed [SUM_W-1:0]    r_sx,         n_sx;
    logic signed [SUM_W-1:0]    r_sy,         n_sy;
    logic                       r_div_go,     n_div_go;

    // result registers
    logic                       r_strobe,     n_strobe;
    logic                       r_emit,       n_emit;
    t_kind                      r_out_kind,   n_out_kind;
    logic [OUT_CNT_W-1:0]       r_pcount,     n_pcount;
    logic signed [COORD_W-1:0]  r_cx,         n_cx;
    logic signed [COORD_W-1:0]  r_cy,         n_cy;
    logic                       r_ovf,        n_ovf;

    t_tbl_wr                    w_wr;
    t_tbl_rd                    w_rd;
    logic                       w_last;
    logic [CNT_W-1:0]           w_new_cnt;
    logic                       w_div_done;
    logic signed [COORD_W-1:0]  w_qx;
    logic signed [COORD_W-1:0]  w_qy;

    // slot table
    mcts_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_rd_idx (r_idx),
        .o_rd     (w_rd)
    );

    // centroid divider
    mcts_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_sum_x   (r_sx),
        .i_sum_y   (r_sy),
        .i_divisor (r_n),
        .o_done    (w_div_done),
        .o_quot_x  (w_qx),
        .o_quot_y  (w_qy)
    );

    assign w_last = (r_idx == IDX_W'(MAX_CONTACTS - 1));

    // next-state and datapath logic
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_x          = r_x;
        n_y          = r_y;
        n_idx        = r_idx;
        n_found      = r_found;
        n_match      = r_match;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_count      = r_count;
        n_n          = r_n;
        n_kind       = r_kind;
        n_active     = r_active;
        n_remove     = r_remove;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_div_go     = 1'b0;
        n_strobe     = 1'b0;
        n_emit       = r_emit;
        n_out_kind   = r_out_kind;
        n_pcount     = r_pcount;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_ovf        = r_ovf;
        w_new_cnt    = r_count;

        w_wr         = '0;
        w_wr.idx     = r_found ? r_match : r_free;
        w_wr.id      = r_id;
        w_wr.x       = r_x;
        w_wr.y       = r_y;

        case (r_state)
            // wait for an event transaction
            S_IDLE: begin
                if (start) begin
                    n_op         = t_opcode'(i_opcode);
                    n_id         = i_contact_id;
                    n_x          = i_x_pos;
                    n_y          = i_y_pos;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_count      = '0;
                    n_state      = S_SCAN;
                end
            end

            // table walk: id match, lowest free slot, live count
            S_SCAN: begin
                if (w_rd.valid && (w_rd.id == r_id) && !r_found) begin
                    n_found = 1'b1;
                    n_match = r_idx;
                end
                if (!w_rd.valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free       = r_idx;
                end
                if (w_rd.valid) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_idx = r_idx + IDX_W'(1);
                if (w_last) begin
                    n_state = S_DECIDE;
                end
            end

            // apply the event, pick a direct result or a centroid pass
            S_DECIDE: begin
                n_emit     = 1'b0;
                n_out_kind = KIND_PRESS;
                n_pcount   = '0;
                n_cx       = '0;
                n_cy       = '0;
                n_ovf      = 1'b0;
                n_idx      = '0;
                n_sx       = '0;
                n_sy       = '0;
                n_remove   = 1'b0;
                n_strobe   = 1'b1;
                n_state    = S_IDLE;
                case (r_op)
                    OP_DOWN: begin
                        if (!r_found && !r_free_found) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_wr.wr_pos = 1'b1;
                            w_wr.set_new = !r_found;
                            w_new_cnt = r_found ? r_count : (r_count + CNT_W'(1));
                            if (w_new_cnt >= CNT_W'(2)) begin
                                n_kind   = r_active ? KIND_MOVE : KIND_PRESS;
                                n_active = 1'b1;
                                n_n      = w_new_cnt;
                                n_strobe = 1'b0;
                                n_state  = S_SUM;
                            end
                        end
                    end
                    OP_MOVE: begin
                        if (r_found) begin
                            w_wr.wr_pos = 1'b1;
                            if (r_active && (r_count >= CNT_W'(2))) begin
                                n_kind   = KIND_MOVE;
                                n_n      = r_count;
                                n_strobe = 1'b0;
                                n_state  = S_SUM;
                            end
                        end
                    end
                    OP_UP: begin
                        if (r_found) begin
                            w_wr.wr_pos = 1'b1;
                            n_active = r_active && (r_count >= CNT_W'(3));
                            if (r_active && (r_count >= CNT_W'(2))) begin
                                // release centroid includes the leaving contact
                                n_kind   = KIND_RELEASE;
                                n_n      = r_count;
                                n_remove = 1'b1;
                                n_strobe = 1'b0;
                                n_state  = S_SUM;
                            end else begin
                                w_wr.clr_one = 1'b1;
                                if (r_active) begin
                                    n_emit     = 1'b1;
                                    n_out_kind = KIND_RELEASE;
                                    n_pcount   = OUT_CNT_W'(2);
                                    n_cx       = r_x;
                                    n_cy       = r_y;
                                end
                            end
                        end
                    end
                    OP_CLEAR: begin
                        w_wr.clr_all = 1'b1;
                        n_active     = 1'b0;
                    end
                    default: begin
                        n_active = r_active;
                    end
                endcase
            end

            // second walk: coordinate sums of live contacts
            S_SUM: begin
                if (w_rd.valid) begin
                    n_sx = r_sx + SUM_W'(w_rd.x);
                    n_sy = r_sy + SUM_W'(w_rd.y);
                end
                n_idx = r_idx + IDX_W'(1);
                if (w_last) begin
                    n_div_go = 1'b1;
                    n_state  = S_DIV;
                end
            end

            // wait for the centroid quotients
            S_DIV: begin
                if (w_div_done) begin
                    n_emit     = 1'b1;
                    n_out_kind = r_kind;
                    n_pcount   = OUT_CNT_W'(r_n);
                    n_cx       = w_qx;
                    n_cy       = w_qy;
                    n_ovf      = 1'b0;
                    n_strobe   = 1'b1;
                    n_state    = S_IDLE;
                    if (r_remove) begin
                        w_wr.clr_one = 1'b1;
                        w_wr.idx     = r_match;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= 1'b0;
            r_div_go   <= 1'b0;
            r_strobe   <= 1'b0;
            r_emit     <= 1'b0;
            r_ovf      <= 1'b0;
            r_pcount   <= '0;
            r_out_kind <= KIND_PRESS;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_div_go   <= n_div_go;
            r_strobe   <= n_strobe;
            r_emit     <= n_emit;
            r_ovf      <= n_ovf;
            r_pcount   <= n_pcount;
            r_out_kind <= n_out_kind;
        end
        r_op         <= n_op;
        r_id         <= n_id;
        r_x          <= n_x;
        r_y          <= n_y;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_match      <= n_match;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_count      <= n_count;
        r_n          <= n_n;
        r_kind       <= n_kind;
        r_remove     <= n_remove;
        r_sx         <= n_sx;
        r_sy         <= n_sy;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_strobe;
    assign o_emit          = r_emit;
    assign o_event_kind    = r_out_kind;
    assign o_pointer_count = r_pcount;
    assign o_center_x      = r_cx;
    assign o_center_y      = r_cy;
    assign o_overflow      = r_ovf;

    // checks
    `MCTS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept not busy")
    `MCTS_ASSERT_IMPLIES(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    `MCTS_ASSERT_IMPLIES(a_emit_count, i_clk, i_rst_n, o_valid && o_emit, (o_pointer_count >= OUT_CNT_W'(2)) && !o_overflow, "bad sample count or overflow")
    `MCTS_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")
    `MCTS_ASSERT_IMPLIES(a_div_in_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "quotient outside divide phase")

endmodule

[rtl/mcts_table.sv]
// ---------------------------------------------------------------------------
// mcts_table
// contact slot table: valid bits, ids and positions, one read port
// ---------------------------------------------------------------------------
module mcts_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcts_pkg::t_tbl_wr            i_wr,
    input  logic [mcts_pkg::IDX_W-1:0]   i_rd_idx,
    output mcts_pkg::t_tbl_rd            o_rd
);
    import mcts_pkg::*;

    logic [MAX_CONTACTS-1:0]    r_valid;
    logic [ID_W-1:0]            r_id [MAX_CONTACTS];
    logic signed [COORD_W-1:0]  r_x  [MAX_CONTACTS];
    logic signed [COORD_W-1:0]  r_y  [MAX_CONTACTS];

    // valid bits, cleared at reset and by a clear-all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.clr_all) begin
            r_valid <= '0;
        end else begin
            if (i_wr.set_new) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_wr.clr_one) begin
                r_valid[i_wr.idx] <= 1'b0;
            end
        end
    end

    // slot payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_pos) begin
            r_x[i_wr.idx] <= i_wr.x;
            r_y[i_wr.idx] <= i_wr.y;
        end
        if (i_wr.set_new) begin
            r_id[i_wr.idx] <= i_wr.id;
        end
    end

    // walk read port
    always_comb begin
        o_rd.valid = r_valid[i_rd_idx];
        o_rd.id    = r_id[i_rd_idx];
        o_rd.x     = r_x[i_rd_idx];
        o_rd.y     = r_y[i_rd_idx];
    end

endmodule

[rtl/mcts_div.sv]
// ---------------------------------------------------------------------------
// mcts_div
// serial restoring divider, x and y sums by the contact count, one bit a cycle
// ---------------------------------------------------------------------------
`include "multitouch_centroid_tracker_unit_macros.svh"

module mcts_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mcts_pkg::SUM_W-1:0]   i_sum_x,
    input  logic signed [mcts_pkg::SUM_W-1:0]   i_sum_y,
    input  logic [mcts_pkg::CNT_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic signed [mcts_pkg::COORD_W-1:0] o_quot_x,
    output logic signed [mcts_pkg::COORD_W-1:0] o_quot_y
);
    import mcts_pkg::*;

    logic                   r_run;
    logic                   r_done;
    logic [DIV_STEP_W-1:0]  r_cnt;
    logic                   r_neg_x;
    logic                   r_neg_y;
    logic [SUM_W-1:0]       r_qx;
    logic [SUM_W-1:0]       r_qy;
    logic [CNT_W-1:0]       r_rx;
    logic [CNT_W-1:0]       r_ry;
    logic [CNT_W-1:0]       r_div;

    logic [SUM_W-1:0]       w_mag_x;
    logic [SUM_W-1:0]       w_mag_y;
    logic [CNT_W+SUM_W-1:0] n_step_x;
    logic [CNT_W+SUM_W-1:0] n_step_y;
    logic [SUM_W-1:0]       w_res_x;
    logic [SUM_W-1:0]       w_res_y;
    logic                   w_last;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [CNT_W+SUM_W-1:0] div_step(
        input logic [CNT_W-1:0] rem,
        input logic [SUM_W-1:0] q,
        input logic [CNT_W-1:0] d
    );
        logic [CNT_W:0] t;
        logic [CNT_W:0] diff;
        logic           qbit;
        t = {rem, q[SUM_W-1]};
        if (t >= {1'b0, d}) begin
            diff = t - {1'b0, d};
            qbit = 1'b1;
        end else begin
            diff = t;
            qbit = 1'b0;
        end
        return {diff[CNT_W-1:0], q[SUM_W-2:0], qbit};
    endfunction

    // magnitudes of the incoming sums
    assign w_mag_x = i_sum_x[SUM_W-1] ? (~i_sum_x + SUM_W'(1)) : i_sum_x;
    assign w_mag_y = i_sum_y[SUM_W-1] ? (~i_sum_y + SUM_W'(1)) : i_sum_y;

    // step datapath, both lanes
    always_comb begin
        n_step_x = div_step(r_rx, r_qx, r_div);
        n_step_y = div_step(r_ry, r_qy, r_div);
    end

    assign w_last = (r_cnt == DIV_STEP_W'(SUM_W - 1));

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= !i_start && r_run && w_last;
            if (i_start) begin
                r_run   <= 1'b1;
                r_cnt   <= '0;
                r_neg_x <= i_sum_x[SUM_W-1];
                r_neg_y <= i_sum_y[SUM_W-1];
                r_qx    <= w_mag_x;
                r_qy    <= w_mag_y;
                r_rx    <= '0;
                r_ry    <= '0;
                r_div   <= i_divisor;
            end else if (r_run) begin
                r_rx  <= n_step_x[CNT_W+SUM_W-1:SUM_W];
                r_qx  <= n_step_x[SUM_W-1:0];
                r_ry  <= n_step_y[CNT_W+SUM_W-1:SUM_W];
                r_qy  <= n_step_y[SUM_W-1:0];
                r_cnt <= r_cnt + DIV_STEP_W'(1);
                if (w_last) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // signed quotients, truncated toward zero
    assign w_res_x  = r_neg_x ? (~r_qx + SUM_W'(1)) : r_qx;
    assign w_res_y  = r_neg_y ? (~r_qy + SUM_W'(1)) : r_qy;
    assign o_quot_x = $signed(w_res_x[COORD_W-1:0]);
    assign o_quot_y = $signed(w_res_y[COORD_W-1:0]);
    assign o_done   = r_done;

    // checks
    `MCTS_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_run, "divider did not start")
    `MCTS_ASSERT_IMPLIES(a_done_not_run, i_clk, i_rst_n, r_done, !r_run, "done while running")
    `MCTS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done && !i_start, !r_done, "done held")

endmodule

[tb/multitouch_centroid_tracker_unit_tb.sv]
// ---------------------------------------------------------------------------
// multitouch_centroid_tracker_unit_tb
// Self-checking bench for the touch contact tracker. Event transactions go in
// through the start/busy handshake with random idle gaps. A built-in contact
// table predicts the gesture sample of every event, and each result strobe
// is checked field by field against the oldest prediction. Directed pair and
// full-table cases come first. Random touch sessions over small id pools
// follow, with some noise events mixed in.
// ---------------------------------------------------------------------------
module multitouch_centroid_tracker_unit_tb;

    import mcts_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 64;

    // one gesture sample as it appears on the result ports
    typedef struct packed {
        logic                       emit;
        logic [1:0]                 kind;
        logic [OUT_CNT_W-1:0]       count;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic                       ovf;
    } gesture_sample_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 i_opcode = OP_CLEAR;
    logic [ID_W-1:0]            i_contact_id = '0;
    logic signed [COORD_W-1:0]  i_x_pos = '0;
    logic signed [COORD_W-1:0]  i_y_pos = '0;
    logic                       o_valid;
    logic                       o_emit;
    logic [1:0]                 o_event_kind;
    logic [OUT_CNT_W-1:0]       o_pointer_count;
    logic signed [COORD_W-1:0]  o_center_x;
    logic signed [COORD_W-1:0]  o_center_y;
    logic                       o_overflow;

    // predicted contact table and gesture flag
    bit                         contact_live [MAX_CONTACTS];
    logic [ID_W-1:0]            contact_tag [MAX_CONTACTS];
    logic signed [COORD_W-1:0]  contact_x [MAX_CONTACTS];
    logic signed [COORD_W-1:0]  contact_y [MAX_CONTACTS];
    bit                         gesture_on;

    gesture_sample_t            expected_samples [$];
    int                         err_count = 0;
    int                         cycle_count = 0;
    int                         no_idle_left = 0;

    multitouch_centroid_tracker_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_contact_id    (i_contact_id),
        .i_x_pos         (i_x_pos),
        .i_y_pos         (i_y_pos),
        .o_valid         (o_valid),
        .o_emit          (o_emit),
        .o_event_kind    (o_event_kind),
        .o_pointer_count (o_pointer_count),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_overflow      (o_overflow)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int live_contacts();
        int n;
        n = 0;
        foreach (contact_live[i]) if (contact_live[i]) n++;
        return n;
    endfunction

    // sample over the live contacts, count at least two
    function automatic gesture_sample_t centroid_sample(input t_kind kind);
        gesture_sample_t s;
        int n, sum_x, sum_y;
        s = '0;
        sum_x = 0;
        sum_y = 0;
        n = live_contacts();
        if (n >= 2) begin
            foreach (contact_live[i]) begin
                if (contact_live[i]) begin
                    sum_x += contact_x[i];
                    sum_y += contact_y[i];
                end
            end
            // int division truncates toward zero
            s.cx = 16'(sum_x / n);
            s.cy = 16'(sum_y / n);
        end else begin
            n = 2;
        end
        s.emit  = 1'b1;
        s.kind  = kind;
        s.count = 5'(n);
        return s;
    endfunction

    // update the predicted table with one event and return its sample
    function automatic gesture_sample_t predict_gesture(input t_opcode op,
                                                        input logic [ID_W-1:0] id,
                                                        input logic signed [COORD_W-1:0] x,
                                                        input logic signed [COORD_W-1:0] y);
        gesture_sample_t res;
        int hit, free_idx;
        res = '0;
        hit = -1;
        free_idx = -1;
        // downward walk leaves the lowest free slot
        for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
            if (contact_live[i] && contact_tag[i] == id) hit = i;
            if (!contact_live[i]) free_idx = i;
        end
        case (op)
            OP_DOWN: begin
                if (hit < 0) begin
                    if (free_idx < 0) begin
                        res.ovf = 1'b1;
                        return res;
                    end
                    hit = free_idx;
                    contact_live[hit] = 1'b1;
                    contact_tag[hit] = id;
                end
                contact_x[hit] = x;
                contact_y[hit] = y;
                if (live_contacts() >= 2) begin
                    res = centroid_sample(gesture_on ? KIND_MOVE : KIND_PRESS);
                    gesture_on = 1'b1;
                end
            end
            OP_MOVE: begin
                if (hit >= 0) begin
                    contact_x[hit] = x;
                    contact_y[hit] = y;
                    if (gesture_on && live_contacts() >= 2)
                        res = centroid_sample(KIND_MOVE);
                end
            end
            OP_UP: begin
                if (hit >= 0) begin
                    contact_x[hit] = x;
                    contact_y[hit] = y;
                    // release carries the centroid before removal
                    if (gesture_on) begin
                        if (live_contacts() >= 2) begin
                            res = centroid_sample(KIND_RELEASE);
                        end else begin
                            res.emit  = 1'b1;
                            res.kind  = KIND_RELEASE;
                            res.count = 5'd2;
                            res.cx    = x;
                            res.cy    = y;
                        end
                    end
                    contact_live[hit] = 1'b0;
                    if (live_contacts() < 2) gesture_on = 1'b0;
                end
            end
            default: begin
                foreach (contact_live[i]) contact_live[i] = 1'b0;
                gesture_on = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom());
        endcase
    endfunction

    // send one event transaction and record its predicted sample
    task automatic send_event(input t_opcode op, input logic [ID_W-1:0] id,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        int gap;
        if (no_idle_left > 0) begin
            no_idle_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 19) == 0) no_idle_left = $urandom_range(5, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            // half the gaps are counted from the end of the previous event
            if ($urandom_range(0, 1) == 1) begin
                @(posedge i_clk);
                while (busy !== 1'b0) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_contact_id <= id;
        i_x_pos      <= x;
        i_y_pos      <= y;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expected_samples.push_back(predict_gesture(op, id, x, y));
    endtask

    // unknown ids, overwrite of a lone contact, press, move, release
    task automatic test_pair_gestures();
        send_event(OP_CLEAR, 32'h0, 16'sd0, 16'sd0);
        send_event(OP_MOVE, 32'h5, 16'sd100, 16'sd100);
        send_event(OP_UP, 32'h5, 16'sd100, 16'sd100);
        send_event(OP_DOWN, 32'h0, 16'sh8000, 16'sh7FFF);
        send_event(OP_DOWN, 32'h0, -16'sd1, 16'sd1);
        // sums of -1 and 1 over two check truncation toward zero
        send_event(OP_DOWN, 32'hFFFF_FFFF, 16'sd0, 16'sd0);
        send_event(OP_MOVE, 32'h0, 16'sh7FFF, 16'sh8000);
        send_event(OP_MOVE, 32'h7, 16'sd1, 16'sd1);
        send_event(OP_UP, 32'hFFFF_FFFF, -16'sd3, 16'sd2);
        send_event(OP_MOVE, 32'h0, 16'sd5, 16'sd5);
        send_event(OP_DOWN, 32'h8000_0001, -16'sd5, -16'sd5);
    endtask

    // fill all slots at the coordinate extremes, then overflow and refill
    task automatic test_table_full();
        send_event(OP_CLEAR, 32'h0, 16'sd0, 16'sd0);
        for (int i = 0; i < MAX_CONTACTS; i++)
            send_event(OP_DOWN, {i[3:0], 28'h0A5_5A5A}, 16'sh8000, 16'sh7FFF);
        send_event(OP_DOWN, 32'h0123_4567, 16'sd9, 16'sd9);
        send_event(OP_DOWN, 32'h00A5_5A5A, 16'sh7FFF, 16'sh8000);
        send_event(OP_UP, 32'h30A5_5A5A, 16'sd0, 16'sd0);
        send_event(OP_DOWN, 32'h0123_4567, 16'sd9, 16'sd9);
    endtask

    // random touch sessions over small id pools, with noise events
    task automatic test_random_sessions(input int n_items);
        logic [ID_W-1:0] pool [$];
        logic [ID_W-1:0] id;
        int counted, pool_len, pick;
        counted = 0;
        while (counted < n_items) begin
            pool.delete();
            pool_len = $urandom_range(2, 20);
            repeat (pool_len) pool.push_back($urandom());
            if ($urandom_range(0, 1) == 1) begin
                send_event(OP_CLEAR, $urandom(), rand_coord(), rand_coord());
                counted++;
            end
            repeat ($urandom_range(4, 40)) begin
                pick = $urandom_range(0, 99);
                id = pool[$urandom_range(0, pool_len - 1)];
                if (pick < 42)
                    send_event(OP_DOWN, id, rand_coord(), rand_coord());
                else if (pick < 66)
                    send_event(OP_MOVE, id, rand_coord(), rand_coord());
                else if (pick < 90)
                    send_event(OP_UP, id, rand_coord(), rand_coord());
                else if (pick < 92)
                    send_event(OP_CLEAR, id, rand_coord(), rand_coord());
                else
                    send_event(t_opcode'($urandom_range(0, 3)), $urandom(),
                               rand_coord(), rand_coord());
                if (pick < 92) counted++;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : sample_check
        gesture_sample_t want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (expected_samples.size() == 0) begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t: unexpected result, expected none, actual emit %0h kind %0h",
                             $time, o_emit, o_event_kind);
            end else begin
                want = expected_samples.pop_front();
                compare_field("o_valid", 16'd1, 16'(o_valid));
                compare_field("o_emit", 16'(want.emit), 16'(o_emit));
                compare_field("o_event_kind", 16'(want.kind), 16'(o_event_kind));
                compare_field("o_pointer_count", 16'(want.count), 16'(o_pointer_count));
                compare_field("o_center_x", want.cx, o_center_x);
                compare_field("o_center_y", want.cy, o_center_y);
                compare_field("o_overflow", 16'(want.ovf), 16'(o_overflow));
            end
        end
    end

    // test sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pair_gestures();
        test_table_full();
        test_random_sessions(1900);
        start <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
